[src/hccs_pkg.sv]
// Package for the cache-control header scanner: the classified byte type,
// the value parser phases, match strings and the prefix-automaton step function.
// No dependencies.
`default_nettype none

package hccs_pkg;

  // byte codes
  localparam logic [7:0] ChrCr    = 8'h0D;
  localparam logic [7:0] ChrLf    = 8'h0A;
  localparam logic [7:0] ChrPlus  = 8'h2B;
  localparam logic [7:0] ChrMinus = 8'h2D;
  localparam logic [7:0] ChrZero  = 8'h30;

  // match strings, first character in the highest used byte
  localparam int PatW = 128;
  localparam int ProgW = 5;

  localparam logic [PatW-1:0] NameText = "cache-control";
  localparam int NameLen = 13;
  localparam logic [PatW-1:0] KeyText = "max-age=";
  localparam int KeyLen = 8;

  localparam int NumDir = 6;
  localparam logic [PatW-1:0] DirText [NumDir] = '{
    "no-cache", "no-store", "private", "max-age=0",
    "must-revalidate", "proxy-revalidate"
  };
  localparam int DirLen [NumDir] = '{8, 8, 7, 9, 15, 16};

  // saturation bound of the value magnitude
  localparam logic [31:0] SatMag = 32'h8000_0000;
  localparam logic [31:0] MaxPos = 32'h7FFF_FFFF;

  // queue between front and back
  localparam int QueueDepth = 4;
  localparam int QueuePtrW = 2;

  typedef enum logic [1:0] {
    VP_SEARCH = 2'd0,
    VP_SPACE  = 2'd1,
    VP_NUMBER = 2'd2,
    VP_DONE   = 2'd3
  } value_phase_e;

  // one header byte after classification
  typedef struct packed {
    logic [7:0] raw;
    logic [7:0] low;
    logic       is_digit;
    logic       is_space;
    logic       is_plus;
    logic       is_minus;
    logic       is_cr;
    logic       is_lf;
    logic       last;
  } hccs_item_t;

  function automatic logic [7:0] pat_chr(input logic [PatW-1:0] pat, input int len,
                                         input int idx);
    return pat[8*(len-1-idx) +: 8];
  endfunction

  // next match length of a constant pattern: longest prefix ending the seen text plus c;
  // the pattern is constant so all border checks fold away
  function automatic logic [ProgW-1:0] kmp_next(input logic [PatW-1:0] pat, input int len,
                                                input logic [ProgW-1:0] p,
                                                input logic [7:0] c);
    logic [ProgW-1:0] res;
    logic             sel;
    logic             border;
    int               q;
    int               k;
    int               i;
    res = '0;
    for (q = 0; q < 16; q++) begin
      if (q < len) begin
        if (q == len - 1) sel = (p >= q[ProgW-1:0]);
        else              sel = (p == q[ProgW-1:0]);
        for (k = 1; k <= 16; k++) begin
          if (k <= q + 1) begin
            border = 1'b1;
            for (i = 0; i < 15; i++) begin
              if (i + 1 < k) begin
                if (pat_chr(pat, len, i) != pat_chr(pat, len, q - k + 1 + i)) border = 1'b0;
              end
            end
            if (sel && border && (pat_chr(pat, len, k - 1) == c)) res = k[ProgW-1:0];
          end
        end
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[src/hccs_front.sv]
// Front stage of the cache-control scanner: accepts header bytes and classifies them.
// Depends on hccs_pkg.
`default_nettype none

module hccs_front import hccs_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output hccs_item_t      out_item_o
);

  logic       valid_q, valid_d;
  hccs_item_t item_q, item_d;
  logic       take;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  // classify the incoming byte
  always_comb begin
    item_d.raw      = in_byte_i;
    item_d.low      = ((in_byte_i >= 8'h41) && (in_byte_i <= 8'h5A)) ?
                      (in_byte_i + 8'd32) : in_byte_i;
    item_d.is_digit = (in_byte_i >= ChrZero) && (in_byte_i <= ChrZero + 8'd9);
    item_d.is_space = (in_byte_i == 8'h20) || ((in_byte_i >= 8'h09) && (in_byte_i <= 8'h0D));
    item_d.is_plus  = (in_byte_i == ChrPlus);
    item_d.is_minus = (in_byte_i == ChrMinus);
    item_d.is_cr    = (in_byte_i == ChrCr);
    item_d.is_lf    = (in_byte_i == ChrLf);
    item_d.last     = in_last_i;
    valid_d         = take ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

[src/hccs_queue.sv]
// Short queue of classified bytes between the front and back of the scanner.
// Depends on hccs_pkg.
`default_nettype none

module hccs_queue import hccs_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       wr_valid_i,
  output logic            wr_ready_o,
  input  wire hccs_item_t wr_item_i,
  output logic            rd_valid_o,
  input  wire logic       rd_ready_i,
  output hccs_item_t      rd_item_o
);

  hccs_item_t             mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueuePtrW:0]     count_q, count_d;
  logic                   push, pop;

  assign wr_ready_o = (count_q != QueueDepth[QueuePtrW:0]);
  assign rd_valid_o = (count_q != '0);
  assign rd_item_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) count_d = count_q + 1'b1;
    if (pop && !push) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

`default_nettype wire

[src/hccs_back.sv]
// Back stage of the cache-control scanner: name, directive and key automata,
// the max-age value parser and the result register. Depends on hccs_pkg.
`default_nettype none

module hccs_back import hccs_pkg::*; #(
  parameter int VALUE_WINDOW = 23
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire hccs_item_t in_item_i,
  output logic            res_valid_o,
  input  wire logic       res_ready_i,
  output logic            res_cacheable_o,
  output logic [31:0]     res_max_age_o
);

  localparam int WinW = $clog2(VALUE_WINDOW + 1);

  logic [ProgW-1:0] name_prog_q, name_prog_d;
  logic             name_found_q, name_found_d;
  logic             in_line_q, in_line_d;
  logic             cr_seen_q, cr_seen_d;
  logic [ProgW-1:0] dir_prog_q [NumDir];
  logic [ProgW-1:0] dir_prog_d [NumDir];
  logic             dir_hit_q, dir_hit_d;
  logic [ProgW-1:0] key_prog_q, key_prog_d;
  value_phase_e     phase_q, phase_d;
  logic [WinW-1:0]  win_q, win_d;
  logic             neg_q, neg_d;
  logic [31:0]      accum_q, accum_d;
  logic             seen_q, seen_d;

  logic             out_valid_q, out_valid_d;
  logic             out_cache_q;
  logic [31:0]      out_age_q;
  logic [31:0]      age_d;

  logic             step;
  logic             emit;
  logic [ProgW-1:0] nxt;
  logic [35:0]      prod;

  assign in_ready_o      = !in_item_i.last || !out_valid_q || res_ready_i;
  assign step            = in_valid_i && in_ready_o;
  assign emit            = step && in_item_i.last;
  assign res_valid_o     = out_valid_q;
  assign res_cacheable_o = out_cache_q;
  assign res_max_age_o   = out_age_q;

  // scanner state update for one byte
  always_comb begin
    name_prog_d  = name_prog_q;
    name_found_d = name_found_q;
    in_line_d    = in_line_q;
    cr_seen_d    = cr_seen_q;
    dir_prog_d   = dir_prog_q;
    dir_hit_d    = dir_hit_q;
    key_prog_d   = key_prog_q;
    phase_d      = phase_q;
    win_d        = win_q;
    neg_d        = neg_q;
    accum_d      = accum_q;
    seen_d       = seen_q;
    nxt          = '0;
    prod         = ({1'b0, accum_q, 3'd0} + {3'd0, accum_q, 1'b0}) +
                   {28'd0, in_item_i.raw - ChrZero};

    if (!name_found_q) begin
      // look for the header name
      nxt = kmp_next(NameText, NameLen, name_prog_q, in_item_i.low);
      if (nxt == NameLen[ProgW-1:0]) begin
        name_found_d = 1'b1;
        in_line_d    = 1'b1;
        cr_seen_d    = 1'b0;
        name_prog_d  = '0;
      end else begin
        name_prog_d = nxt;
      end
    end else begin
      // directives on the control line
      if (in_line_q) begin
        if (cr_seen_q && in_item_i.is_lf) begin
          in_line_d = 1'b0;
        end else begin
          for (int j = 0; j < NumDir; j++) begin
            dir_prog_d[j] = kmp_next(DirText[j], DirLen[j], dir_prog_q[j], in_item_i.low);
            if (dir_prog_d[j] == DirLen[j][ProgW-1:0]) begin
              dir_hit_d     = 1'b1;
              dir_prog_d[j] = '0;
            end
          end
        end
        cr_seen_d = in_line_d && in_item_i.is_cr;
      end

      // max-age key and value
      case (phase_q)
        VP_SEARCH: begin
          nxt = kmp_next(KeyText, KeyLen, key_prog_q, in_item_i.low);
          if (nxt == KeyLen[ProgW-1:0]) begin
            phase_d    = VP_SPACE;
            win_d      = '0;
            key_prog_d = '0;
          end else begin
            key_prog_d = nxt;
          end
        end
        VP_SPACE, VP_NUMBER: begin
          win_d = win_q + 1'b1;
          if (in_item_i.is_digit) begin
            accum_d = (prod > {4'd0, SatMag}) ? SatMag : prod[31:0];
            seen_d  = 1'b1;
            phase_d = VP_NUMBER;
          end else if ((phase_q == VP_SPACE) && (in_item_i.is_plus || in_item_i.is_minus)) begin
            neg_d   = in_item_i.is_minus;
            phase_d = VP_NUMBER;
          end else if (!((phase_q == VP_SPACE) && in_item_i.is_space)) begin
            phase_d = VP_DONE;
          end
          if (win_d >= VALUE_WINDOW[WinW-1:0]) phase_d = VP_DONE;
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  // result value from the updated state
  always_comb begin
    if (!seen_d)     age_d = 32'hFFFF_FFFF;
    else if (neg_d)  age_d = 32'd0 - accum_d;
    else             age_d = (accum_d > MaxPos) ? MaxPos : accum_d;
    out_valid_d = emit ? 1'b1 : (res_ready_i ? 1'b0 : out_valid_q);
  end

  // state registers, cleared after each header
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_prog_q  <= '0;
      name_found_q <= 1'b0;
      in_line_q    <= 1'b0;
      cr_seen_q    <= 1'b0;
      dir_prog_q   <= '{default: '0};
      dir_hit_q    <= 1'b0;
      key_prog_q   <= '0;
      phase_q      <= VP_SEARCH;
      win_q        <= '0;
      neg_q        <= 1'b0;
      accum_q      <= '0;
      seen_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (emit) begin
        name_prog_q  <= '0;
        name_found_q <= 1'b0;
        in_line_q    <= 1'b0;
        cr_seen_q    <= 1'b0;
        dir_prog_q   <= '{default: '0};
        dir_hit_q    <= 1'b0;
        key_prog_q   <= '0;
        phase_q      <= VP_SEARCH;
        win_q        <= '0;
        neg_q        <= 1'b0;
        accum_q      <= '0;
        seen_q       <= 1'b0;
      end else if (step) begin
        name_prog_q  <= name_prog_d;
        name_found_q <= name_found_d;
        in_line_q    <= in_line_d;
        cr_seen_q    <= cr_seen_d;
        dir_prog_q   <= dir_prog_d;
        dir_hit_q    <= dir_hit_d;
        key_prog_q   <= key_prog_d;
        phase_q      <= phase_d;
        win_q        <= win_d;
        neg_q        <= neg_d;
        accum_q      <= accum_d;
        seen_q       <= seen_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_cache_q <= !dir_hit_d;
      out_age_q   <= age_d;
    end
  end

endmodule

`default_nettype wire

[src/http_cache_control_scanner_top.sv]
// Top level of the HTTP cache-control scanner: front classifier, byte queue and
// back-end scanner. Depends on hccs_pkg, hccs_front, hccs_queue and hccs_back.
//
// Usage: the response header enters on the s_axis channel one byte per
// transaction, with s_axis_tlast on the final byte. For each header exactly
// one result transaction leaves on m_axis, carrying the cacheable flag and
// the signed max-age value (-1 when no value was found).
// Throughput: one byte per cycle while no result is held back on m_axis; every byte
// goes through the classifier register, a four-entry queue and the scanner step.
// Result path: the final byte of a header is held in the classifier register, written
// into the queue and read by the scanner step, which loads the result register.
// The next header may follow directly after the final byte of the previous.
// Reset: all scanner state, the queue and the result valid flag clear; the
// scanner also returns to its reset state after each final byte.
// Stall: while m_axis_tready is low the result waits in its register; bytes
// keep flowing until the next final byte reaches the scanner, then the queue
// fills and s_axis_tready drops.
`default_nettype none

module http_cache_control_scanner_top import hccs_pkg::*; #(
  parameter int VALUE_WINDOW = 23
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] header_byte
  input  wire logic        s_axis_tlast,   // last_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata    // [0] cacheable, [32:1] max_age, [39:33] zero
);

  logic       f_valid, f_ready;
  hccs_item_t f_item;
  logic       q_valid, q_ready;
  hccs_item_t q_item;
  logic       res_cache;
  logic [31:0] res_age;

  // byte classifier
  hccs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_item_o  (f_item)
  );

  // decoupling queue
  hccs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_item_i  (f_item),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_item_o  (q_item)
  );

  // scanner and result register
  hccs_back #(
    .VALUE_WINDOW (VALUE_WINDOW)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (q_valid),
    .in_ready_o      (q_ready),
    .in_item_i       (q_item),
    .res_valid_o     (m_axis_tvalid),
    .res_ready_i     (m_axis_tready),
    .res_cacheable_o (res_cache),
    .res_max_age_o   (res_age)
  );

  assign m_axis_tdata = {7'd0, res_age, res_cache};

endmodule

`default_nettype wire
